[rtl/krpt_pkg.sv]
// ============================================================================
// krpt_pkg
// Shared types and codes for the key repeat press tracker.
// ============================================================================
package krpt_pkg;

  // Item mode codes.
  localparam logic [2:0] MODE_FRAME        = 3'd0;
  localparam logic [2:0] MODE_TAKE_PRESS   = 3'd1;
  localparam logic [2:0] MODE_TAKE_RELEASE = 3'd2;
  localparam logic [2:0] MODE_TAKE_REPEAT  = 3'd3;
  localparam logic [2:0] MODE_READ_PRESSES = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_REPEAT_DELAY    = 1'b0;
  localparam logic CFG_REPEAT_INTERVAL = 1'b1;

  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ELAPSED_W  = 20;

  typedef struct packed {
    logic [2:0]           mode;
    logic                 level_now;
    logic                 suppress;
    logic [ELAPSED_W-1:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic             held;
    logic             taken;
    logic [CNT_W-1:0] press_count;
  } out_item_t;

endpackage

[rtl/krpt_if.sv]
// ============================================================================
// krpt_if
// Valid/ready channels carrying input items and result items.
// ============================================================================
interface krpt_in_if;
  logic               valid;
  logic               ready;
  krpt_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface krpt_out_if;
  logic                valid;
  logic                ready;
  krpt_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[rtl/key_repeat_press_tracker_unit.sv]
// ============================================================================
// key_repeat_press_tracker_unit
// Typematic autorepeat tracker for one digital action.
// ============================================================================
// The unit takes one beat per clock while the result side is not stalled, and
// returns exactly one result beat for each. A
// beat first lands in an input register; the whole state update for it (edge
// counting, held timer, repeat mark and the event queries) is one pass of
// add and compare logic between that register and the result register, so
// the rate is set by that single pass and is one beat per cycle. The input
// side keeps accepting while a finished result waits, as long as the input
// register can move forward into the result register. Configuration writes
// are taken at any edge with cfg_we high, and are meant to be made while no
// beat is in flight.
module key_repeat_press_tracker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  krpt_in_if.sink                             in_bus,
  krpt_out_if.source                          out_bus,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [krpt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [krpt_pkg::CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [krpt_pkg::TIME_W-1:0] TIME_MAX = '1;

  // Configuration registers.
  logic [krpt_pkg::CFG_DATA_W-1:0] repeat_delay_r;
  logic [krpt_pkg::CFG_DATA_W-1:0] repeat_interval_r;

  // Tracker state.
  logic                        held_level_r,     held_level_nxt;
  logic [krpt_pkg::TIME_W-1:0] held_time_r,      held_time_nxt;
  logic [krpt_pkg::TIME_W-1:0] next_mark_r,      next_mark_nxt;
  logic [krpt_pkg::CNT_W-1:0]  press_events_r,   press_events_nxt;
  logic [krpt_pkg::CNT_W-1:0]  release_events_r, release_events_nxt;
  logic [krpt_pkg::CNT_W-1:0]  repeat_events_r,  repeat_events_nxt;

  // Input register and result register.
  logic                s1_valid_r;
  krpt_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  krpt_pkg::out_item_t out_item_r;
  krpt_pkg::out_item_t result_nxt;

  logic advance;
  logic in_fire;

  // The input register moves on when the result register is free or drains.
  assign advance      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || advance;
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign out_bus.valid = out_valid_r;
  assign out_bus.item  = out_item_r;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_delay_r    <= '0;
      repeat_interval_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        krpt_pkg::CFG_REPEAT_DELAY:    repeat_delay_r    <= cfg_data;
        krpt_pkg::CFG_REPEAT_INTERVAL: repeat_interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Single-pass update of the tracker state for the beat in the input register.
  logic [krpt_pkg::TIME_W:0]     time_sum;
  logic [krpt_pkg::TIME_W-1:0]   time_sat;
  logic [krpt_pkg::TIME_W-1:0]   delay_ext;
  logic [krpt_pkg::TIME_W-1:0]   step_ext;
  logic [krpt_pkg::TIME_W-1:0]   mark_floor;
  logic [krpt_pkg::TIME_W:0]     mark_sum;
  logic [krpt_pkg::TIME_W-1:0]   mark_sat;
  logic                          repeat_armed;
  logic                          repeat_due;

  always_comb begin
    delay_ext = {{(krpt_pkg::TIME_W - krpt_pkg::CFG_DATA_W){1'b0}}, repeat_delay_r};
    step_ext  = (repeat_interval_r != '0)
              ? {{(krpt_pkg::TIME_W - krpt_pkg::CFG_DATA_W){1'b0}}, repeat_interval_r}
              : delay_ext;

    // Held timer advances with saturation.
    time_sum = {1'b0, held_time_r}
             + {{(krpt_pkg::TIME_W + 1 - krpt_pkg::ELAPSED_W){1'b0}},
                s1_item_r.elapsed_us};
    time_sat = time_sum[krpt_pkg::TIME_W] ? TIME_MAX : time_sum[krpt_pkg::TIME_W-1:0];

    repeat_armed = (repeat_delay_r != '0) && (time_sat >= delay_ext);
    mark_floor   = (next_mark_r < delay_ext) ? delay_ext : next_mark_r;
    repeat_due   = repeat_armed && (time_sat >= mark_floor);
    mark_sum     = {1'b0, mark_floor} + {1'b0, step_ext};
    mark_sat     = mark_sum[krpt_pkg::TIME_W] ? TIME_MAX : mark_sum[krpt_pkg::TIME_W-1:0];

    held_level_nxt     = held_level_r;
    held_time_nxt      = held_time_r;
    next_mark_nxt      = next_mark_r;
    press_events_nxt   = press_events_r;
    release_events_nxt = release_events_r;
    repeat_events_nxt  = repeat_events_r;
    result_nxt.taken       = 1'b0;
    result_nxt.press_count = '0;

    case (s1_item_r.mode)
      krpt_pkg::MODE_FRAME: begin
        if (s1_item_r.suppress) begin
          // Forced release keeps the repeat mark and skips timing.
          if (held_level_r) begin
            held_level_nxt = 1'b0;
            held_time_nxt  = '0;
            if (release_events_r != CNT_MAX) begin
              release_events_nxt = release_events_r + 1'b1;
            end
          end
        end else begin
          if (s1_item_r.level_now && !held_level_r && press_events_r != CNT_MAX) begin
            press_events_nxt = press_events_r + 1'b1;
          end
          if (!s1_item_r.level_now && held_level_r && release_events_r != CNT_MAX) begin
            release_events_nxt = release_events_r + 1'b1;
          end
          held_level_nxt = s1_item_r.level_now;
          if (s1_item_r.level_now) begin
            held_time_nxt = time_sat;
            if (repeat_armed) begin
              next_mark_nxt = mark_floor;
            end
            if (repeat_due) begin
              next_mark_nxt = mark_sat;
              if (repeat_events_r != CNT_MAX) begin
                repeat_events_nxt = repeat_events_r + 1'b1;
              end
            end
          end else begin
            held_time_nxt = '0;
            next_mark_nxt = '0;
          end
        end
      end
      krpt_pkg::MODE_TAKE_PRESS: begin
        if (press_events_r != '0) begin
          press_events_nxt = press_events_r - 1'b1;
          result_nxt.taken = 1'b1;
        end
      end
      krpt_pkg::MODE_TAKE_RELEASE: begin
        if (release_events_r != '0) begin
          release_events_nxt = release_events_r - 1'b1;
          result_nxt.taken   = 1'b1;
        end
      end
      krpt_pkg::MODE_TAKE_REPEAT: begin
        if (repeat_events_r != '0) begin
          repeat_events_nxt = repeat_events_r - 1'b1;
          result_nxt.taken  = 1'b1;
        end
      end
      krpt_pkg::MODE_READ_PRESSES: begin
        result_nxt.press_count = press_events_r;
        press_events_nxt       = '0;
      end
      default: ;
    endcase

    result_nxt.held = held_level_nxt;
  end

  // Pipeline control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      held_level_r     <= 1'b0;
      held_time_r      <= '0;
      next_mark_r      <= '0;
      press_events_r   <= '0;
      release_events_r <= '0;
      repeat_events_r  <= '0;
    end else begin
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r      <= 1'b1;
        held_level_r     <= held_level_nxt;
        held_time_r      <= held_time_nxt;
        next_mark_r      <= next_mark_nxt;
        press_events_r   <= press_events_nxt;
        release_events_r <= release_events_nxt;
        repeat_events_r  <= repeat_events_nxt;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_bus.item;
    end
    if (advance) begin
      out_item_r <= result_nxt;
    end
  end

  // A released action never carries a running hold timer.
  assert property (@(posedge clk) disable iff (!rst_n)
    !held_level_r |-> (held_time_r == '0))
    else $error("hold timer nonzero while released");

  // A result carries either a taken flag or a press count, never both.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.taken && (out_item_r.press_count != '0)))
    else $error("result has both taken and press count");

  // While the result side is stalled with a beat waiting, the state holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_bus.ready) |=>
      ($stable(press_events_r) && $stable(held_level_r) && $stable(repeat_events_r)))
    else $error("state changed while result stalled");

  // A repeat tick is only counted while the action is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (repeat_events_r == ($past(repeat_events_r) + 1'b1)) && $past(rst_n)
      && ($past(repeat_events_r) != CNT_MAX) |-> held_level_r)
    else $error("repeat tick counted while released");

endmodule

[sim/press_tracker_sb_pkg.sv]
// ============================================================================
// press_tracker_sb_pkg
// Scoreboard for the key repeat press tracker: predicts each result beat.
// ============================================================================
// The scoreboard keeps its own copy of the tracker state and the two repeat
// registers. Every accepted input beat advances that state and queues one
// predicted status. Every accepted result beat is compared field by field
// against the oldest prediction.
package press_tracker_sb_pkg;
  import krpt_pkg::*;

  class press_tracker_scoreboard;
    logic [CFG_DATA_W-1:0] delay_us;
    logic [CFG_DATA_W-1:0] interval_us;
    logic                  held;
    logic [TIME_W-1:0]     held_time;
    logic [TIME_W-1:0]     next_mark;
    logic [CNT_W-1:0]      presses;
    logic [CNT_W-1:0]      releases;
    logic [CNT_W-1:0]      repeats;
    out_item_t             predicted_status_q[$];
    int unsigned           mismatches;

    function new();
      delay_us    = '0;
      interval_us = '0;
      held        = 1'b0;
      held_time   = '0;
      next_mark   = '0;
      presses     = '0;
      releases    = '0;
      repeats     = '0;
      mismatches  = 0;
    endfunction

    function void load_register(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_REPEAT_DELAY)
        delay_us = value;
      else
        interval_us = value;
    endfunction

    function int unsigned pending();
      return predicted_status_q.size();
    endfunction

    function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function logic [TIME_W-1:0] time_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function logic take_event(inout logic [CNT_W-1:0] cnt);
      if (cnt == '0)
        return 1'b0;
      cnt = cnt - 1'b1;
      return 1'b1;
    endfunction

    // One frame: edge counting, then the held timer and the repeat mark.
    function void advance_frame(logic level, logic sup, logic [ELAPSED_W-1:0] dt);
      logic [TIME_W-1:0] step;
      if (sup) begin
        // A suppressed frame only forces a release; the mark survives.
        if (held) begin
          held      = 1'b0;
          held_time = '0;
          releases  = count_up(releases);
        end
        return;
      end
      if (level != held) begin
        if (level)
          presses = count_up(presses);
        else
          releases = count_up(releases);
      end
      held = level;
      if (held) begin
        held_time = time_add(held_time, TIME_W'(dt));
        if (delay_us != '0 && held_time >= TIME_W'(delay_us)) begin
          step = (interval_us != '0) ? TIME_W'(interval_us) : TIME_W'(delay_us);
          if (next_mark < TIME_W'(delay_us))
            next_mark = TIME_W'(delay_us);
          if (held_time >= next_mark) begin
            repeats   = count_up(repeats);
            next_mark = time_add(next_mark, step);
          end
        end
      end else begin
        held_time = '0;
        next_mark = '0;
      end
    endfunction

    function void track_beat(in_item_t b);
      out_item_t r;
      r = '0;
      case (b.mode)
        MODE_FRAME:        advance_frame(b.level_now, b.suppress, b.elapsed_us);
        MODE_TAKE_PRESS:   r.taken = take_event(presses);
        MODE_TAKE_RELEASE: r.taken = take_event(releases);
        MODE_TAKE_REPEAT:  r.taken = take_event(repeats);
        MODE_READ_PRESSES: begin
          r.press_count = presses;
          presses       = '0;
        end
        default: ;
      endcase
      r.held = held;
      predicted_status_q.push_back(r);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
    endtask

    task compare_status(out_item_t got);
      out_item_t want;
      if (predicted_status_q.size() == 0) begin
        report("result beat with nothing predicted", got, 0);
        return;
      end
      want = predicted_status_q.pop_front();
      if (got.held !== want.held)
        report("held", got.held, want.held);
      if (got.taken !== want.taken)
        report("taken", got.taken, want.taken);
      if (got.press_count !== want.press_count)
        report("press_count", got.press_count, want.press_count);
    endtask
  endclass

endpackage

[sim/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking bench for key_repeat_press_tracker_unit.
// ============================================================================
// Drives input beats, configuration writes and result back-pressure, and
// checks every result beat against a scoreboard that predicts the tracker
// state. A directed opening covers edges, suppression, queries and repeat
// timing; random phases then vary idling on both sides over several repeat
// settings, including both extremes of the repeat registers.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import krpt_pkg::*;
  import press_tracker_sb_pkg::*;

  localparam int unsigned ELAPSED_MAX       = (1 << ELAPSED_W) - 1;
  localparam int unsigned CFG_MAX           = (1 << CFG_DATA_W) - 1;
  localparam int unsigned ITEMS_PER_SETTING = 58;
  localparam int unsigned SETTINGS_PER_PASS = 6;
  localparam int unsigned LIMIT_CYCLES      = 1_000_000;

  bit                    clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  krpt_in_if  in_ch();
  krpt_out_if out_ch();

  key_repeat_press_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  press_tracker_scoreboard sb = new();

  // Knobs shared between the stimulus and the result-side process.
  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned hold_cycles;
  // The level the random stimulus is currently holding the key at, and the
  // delay in force, which scales frame times so repeats actually happen.
  bit          key_down;
  int unsigned cur_delay;
  int unsigned cycle_count;

  // 4 ns clock, low half first so nothing sees an edge at time zero.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge. The input beat is noted
  // before the result beat is checked, although a result can never belong
  // to a beat accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.track_beat(in_ch.item);
      if (out_ch.valid && out_ch.ready)
        sb.compare_status(out_ch.item);
    end
  end

  // Result side. Normally ready is rolled every cycle against stall_pct. When
  // a long hold-off is requested, ready stays low for a length taken from
  // hold_cycles and counted here, while the sender keeps offering beats so
  // the pipeline fills up and the block has to push back on its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int n = 0; n < hold_cycles; n++)
          @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one beat and returns at the edge that accepts it. Valid stays high
  // on return, so back-to-back beats leave no bubble unless an idle cycle is
  // rolled at the next falling edge.
  task send_item(input in_item_t b);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task send(input logic [2:0] mode, input logic level, input logic sup,
            input logic [ELAPSED_W-1:0] dt);
    in_item_t b;
    b.mode       = mode;
    b.level_now  = level;
    b.suppress   = sup;
    b.elapsed_us = dt;
    send_item(b);
  endtask

  // Stops offering and waits until every predicted result has come back,
  // then lets the pipeline settle.
  task drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_we high so that back-to-back writes need no gap; set_repeat
  // drops it after the last one.
  task write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.load_register(idx, value);
  endtask

  // Only called with the block idle, i.e. right after reset or a drain.
  task set_repeat(input int unsigned delay_us, input int unsigned interval_us);
    write_reg(CFG_REPEAT_DELAY, CFG_DATA_W'(delay_us));
    write_reg(CFG_REPEAT_INTERVAL, CFG_DATA_W'(interval_us));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_delay = delay_us;
  endtask

  // Random beat. Most frames follow a slowly changing key level so that holds
  // last long enough to reach the repeat delay; the rest are event queries,
  // occasional suppressed frames and a few beats in the unused mode codes.
  function automatic in_item_t make_beat();
    in_item_t    b;
    int unsigned roll;
    int unsigned span;
    b.level_now = 1'($urandom_range(1));
    b.suppress  = ($urandom_range(99) < 8);
    roll = $urandom_range(99);
    span = cur_delay / 3 + 1;
    if (span > ELAPSED_MAX)
      span = ELAPSED_MAX;
    if (roll < 10)
      b.elapsed_us = '0;
    else if (roll < 20)
      b.elapsed_us = '1;
    else if (roll < 55)
      b.elapsed_us = ELAPSED_W'($urandom_range(ELAPSED_MAX));
    else
      b.elapsed_us = ELAPSED_W'($urandom_range(span));
    roll = $urandom_range(99);
    if (roll < 58) begin
      if ($urandom_range(99) < 15)
        key_down = !key_down;
      b.mode      = MODE_FRAME;
      b.level_now = key_down;
    end else if (roll < 96) begin
      b.mode = 3'($urandom_range(MODE_READ_PRESSES, MODE_TAKE_PRESS));
    end else begin
      b.mode = 3'($urandom_range(3'h7, MODE_READ_PRESSES + 3'd1));
    end
    return b;
  endfunction

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_REPEAT_DELAY;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.item      = '0;
    out_ch.ready    = 1'b0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_req        = 1'b0;
    hold_cycles     = 0;
    key_down        = 1'b0;
    cur_delay       = 0;
    cycle_count     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // ---- Directed: repeat disabled -------------------------------------
    // With a zero delay a held key never repeats. This block walks through
    // a press, each query, press and release takes on empty and non-empty
    // counters, a release forced by suppression, a suppressed frame with
    // nothing held, unused mode codes and queries with all side fields set.
    set_repeat(0, 0);
    send(MODE_FRAME, 1'b1, 1'b0, '1);
    send(MODE_FRAME, 1'b1, 1'b0, '1);
    send(MODE_TAKE_PRESS, 1'b0, 1'b0, '0);
    send(MODE_TAKE_PRESS, 1'b1, 1'b1, '1);
    send(MODE_TAKE_REPEAT, 1'b0, 1'b0, '0);
    send(MODE_FRAME, 1'b0, 1'b1, 20'd5);
    send(MODE_FRAME, 1'b1, 1'b1, 20'd5);
    send(MODE_TAKE_RELEASE, 1'b1, 1'b0, '0);
    send(MODE_FRAME, 1'b1, 1'b0, '0);
    send(MODE_READ_PRESSES, 1'b1, 1'b1, '1);
    send(3'd5, 1'b1, 1'b1, '1);
    send(3'd6, 1'b0, 1'b0, '0);
    send(3'd7, 1'b1, 1'b0, '1);
    send(MODE_FRAME, 1'b0, 1'b0, '0);
    send(MODE_TAKE_RELEASE, 1'b0, 1'b0, '0);
    send(MODE_TAKE_RELEASE, 1'b0, 1'b0, '0);
    drain();

    // ---- Directed: repeat timing ----------------------------------------
    // A zero interval falls back to the delay, so ticks come every 10 us.
    // The suppressed frame drops the key but keeps the mark at 30 us, so
    // after the re-press the tick waits until the timer reaches 30 again.
    set_repeat(10, 0);
    send(MODE_FRAME, 1'b1, 1'b0, 20'd10);
    send(MODE_FRAME, 1'b1, 1'b0, 20'd5);
    send(MODE_FRAME, 1'b1, 1'b0, 20'd5);
    send(MODE_FRAME, 1'b1, 1'b1, 20'd0);
    send(MODE_FRAME, 1'b1, 1'b0, 20'd25);
    send(MODE_FRAME, 1'b1, 1'b0, 20'd5);
    repeat (4) send(MODE_TAKE_REPEAT, 1'b0, 1'b0, '0);
    drain();

    // ---- Random phases ---------------------------------------------------
    // Four idling profiles: none, sender idle, receiver stalling, and both
    // lightly. Each runs through the same spread of repeat settings,
    // including both extremes. Every setting change is preceded by a full
    // drain, which also serves as the sender pausing until all results are in.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 64; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 64; end
        default: begin sender_idle_pct = 17; stall_pct = 17; end
      endcase
      for (int s = 0; s < SETTINGS_PER_PASS; s++) begin
        drain();
        case (s)
          0: set_repeat(0, 0);
          1: set_repeat(CFG_MAX, CFG_MAX);
          2: set_repeat(1, 0);
          3: set_repeat($urandom_range(5000, 100), $urandom_range(3000, 1));
          4: set_repeat($urandom_range(CFG_MAX), 0);
          default: set_repeat($urandom_range(CFG_MAX), $urandom_range(CFG_MAX));
        endcase
        for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
          // Once, with no idling on the input, the receiver goes quiet for a
          // long stretch while beats keep coming.
          if (p == 0 && s == 3 && k == 10) begin
            hold_cycles = 400;
            hold_req    = 1'b1;
          end
          send_item(make_beat());
        end
      end
    end
    drain();

    // Extra cycles to catch any stray result beat after the last one.
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/krpt_pkg.sv
rtl/krpt_if.sv
rtl/key_repeat_press_tracker_unit.sv
sim/press_tracker_sb_pkg.sv
sim/tb_top.sv
